// ----- rtl/core/ptc_pkg.sv -----
// Shared types, constants and helpers for the pressure/temperature compensation block.
// No dependencies.
package ptc_pkg;

   localparam int unsigned NumRegs = 5;
   localparam int unsigned AddrWidth = 5;

   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2 = 3'd3;
   localparam logic [2:0] REG_MC_MD = 3'd4;

   localparam logic CMD_TEMP = 1'b0;
   localparam logic CMD_PRES = 1'b1;

   // divider request/response between sequencer and divider
   typedef struct packed {
      logic start;
      logic is_signed;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] quotient;
   } div_rsp_type;

   // signed divide by 2^k truncating toward zero
   function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
      logic [31:0] bias;
      logic [31:0] sum;
      begin
         bias = (32'd1 << k) - 32'd1;
         sum = a[31] ? (a + bias) : a;
         sdiv_pow2 = $signed(sum) >>> k;
      end
   endfunction

endpackage

// ----- rtl/core/ptc_div.sv -----
// Iterative 32-bit divider, one quotient bit per cycle, signed or unsigned.
// Depends on ptc_pkg.
module ptc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ptc_pkg::div_req_type req,
   output ptc_pkg::div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;
   logic [31:0] a_mag;
   logic [31:0] b_mag;

   always_comb begin
      a_mag = (req.is_signed && req.dividend[31]) ? (32'd0 - req.dividend) : req.dividend;
      b_mag = (req.is_signed && req.divisor[31]) ? (32'd0 - req.divisor) : req.divisor;
      shifted = {rem_ff[31:0], quo_ff[31]};
      trial = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         quo_in = a_mag;
         rem_in = 33'd0;
         dvs_in = b_mag;
         neg_in = req.is_signed && (req.dividend[31] ^ req.divisor[31]);
      end else if (busy_ff) begin
         if (trial[32]) begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // negation wraps most negative / -1 to itself
   assign rsp.done = done_ff;
   assign rsp.quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !req.start |=> busy_ff || done_ff) else $error("divider lost");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");

endmodule

// ----- rtl/core/ptc_seq.sv -----
// Sequencer: walks the compensation steps through one shared multiplier and the divider.
// Depends on ptc_pkg and ptc_div.
module ptc_seq (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        cmd,
   input  logic [15:0] raw_reading,
   input  logic [31:0] reg0,
   input  logic [31:0] reg1,
   input  logic [31:0] reg2,
   input  logic [31:0] reg3,
   input  logic [31:0] reg4,
   output logic        done,
   output logic [31:0] value,
   output logic        fault
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_T1 = 5'd1;
   localparam logic [4:0] S_T2 = 5'd2;
   localparam logic [4:0] S_TDIV = 5'd3;
   localparam logic [4:0] S_TOUT = 5'd4;
   localparam logic [4:0] S_P1 = 5'd5;
   localparam logic [4:0] S_P2 = 5'd6;
   localparam logic [4:0] S_P3 = 5'd7;
   localparam logic [4:0] S_P4 = 5'd8;
   localparam logic [4:0] S_P5 = 5'd9;
   localparam logic [4:0] S_P6 = 5'd10;
   localparam logic [4:0] S_P7 = 5'd11;
   localparam logic [4:0] S_P8 = 5'd12;
   localparam logic [4:0] S_P9 = 5'd13;
   localparam logic [4:0] S_PDIV = 5'd14;
   localparam logic [4:0] S_P10 = 5'd15;
   localparam logic [4:0] S_P11 = 5'd16;
   localparam logic [4:0] S_P12 = 5'd17;
   localparam logic [4:0] S_P13 = 5'd18;
   localparam logic [4:0] S_TDIV10 = 5'd19;

   logic [4:0]  state_ff, state_in;
   logic [15:0] raw_ff, raw_in;
   logic [31:0] b5_ff, b5_in;
   logic [31:0] x1_ff, x1_in;
   logic [31:0] b6_ff, b6_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] b7_ff, b7_in;
   logic [31:0] p_ff, p_in;
   logic        hi_ff, hi_in;
   logic [31:0] res_ff, res_in;
   logic        flt_ff, flt_in;
   logic        done_ff, done_in;
   logic [31:0] ma, mb, prod;
   logic [63:0] prod64;
   logic [31:0] raw32;
   logic [31:0] tmp;
   ptc_pkg::div_req_type dreq;
   ptc_pkg::div_rsp_type drsp;

   ptc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign raw32 = {16'd0, raw_ff};
   assign prod64 = {32'd0, ma} * {32'd0, mb};
   assign prod = prod64[31:0];

   always_comb begin
      state_in = state_ff;
      raw_in = raw_ff;
      b5_in = b5_ff;
      x1_in = x1_ff;
      b6_in = b6_ff;
      sq_in = sq_ff;
      acc_in = acc_ff;
      b7_in = b7_ff;
      p_in = p_ff;
      hi_in = hi_ff;
      res_in = res_ff;
      flt_in = flt_ff;
      done_in = 1'b0;
      ma = 32'd0;
      mb = 32'd0;
      tmp = 32'd0;
      dreq = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               flt_in = 1'b0;
               res_in = 32'd0;
               raw_in = raw_reading;
               state_in = (cmd == ptc_pkg::CMD_TEMP) ? S_T1 : S_P1;
            end
         end
         S_T1: begin
            ma = raw32 - {16'd0, reg2[15:0]};
            mb = {16'd0, reg2[31:16]};
            x1_in = ptc_pkg::sdiv_pow2(prod, 5'd15);
            state_in = S_T2;
         end
         S_T2: begin
            ma = 32'd2048;
            mb = {{16{reg4[31]}}, reg4[31:16]};
            tmp = x1_ff + {{16{reg4[15]}}, reg4[15:0]};
            if (tmp == 32'd0) begin
               flt_in = 1'b1;
               done_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               dreq.start = 1'b1;
               dreq.is_signed = 1'b1;
               dreq.dividend = prod;
               dreq.divisor = tmp;
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            if (drsp.done) begin
               b5_in = x1_ff + drsp.quotient;
               state_in = S_TOUT;
            end
         end
         S_TOUT: begin
            acc_in = ptc_pkg::sdiv_pow2(b5_ff + 32'd8, 5'd4);
            state_in = S_TDIV10;
         end
         S_TDIV10: begin
            // divide the magnitude by ten with a reciprocal multiply, then restore the sign
            ma = acc_ff[31] ? (32'd0 - acc_ff) : acc_ff;
            mb = 32'd214748365;
            tmp = 32'(prod64 >> 31);
            res_in = acc_ff[31] ? (32'd0 - tmp) : tmp;
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         S_P1: begin
            b6_in = b5_ff - 32'd4000;
            state_in = S_P2;
         end
         S_P2: begin
            ma = b6_ff;
            mb = b6_ff;
            sq_in = ptc_pkg::sdiv_pow2(prod, 5'd12);
            state_in = S_P3;
         end
         S_P3: begin
            ma = {{16{reg3[15]}}, reg3[15:0]};
            mb = sq_ff;
            acc_in = ptc_pkg::sdiv_pow2(prod, 5'd11);
            state_in = S_P4;
         end
         S_P4: begin
            ma = {{16{reg0[15]}}, reg0[15:0]};
            mb = b6_ff;
            tmp = acc_ff + ptc_pkg::sdiv_pow2(prod, 5'd11);
            // b3 = (ac1*4 + x3 + 2) / 4
            x1_in = ptc_pkg::sdiv_pow2(({{16{reg0[31]}}, reg0[31:16]} << 2) + tmp + 32'd2,
                                       5'd2);
            state_in = S_P5;
         end
         S_P5: begin
            ma = raw32 - x1_ff;
            mb = 32'd50000;
            b7_in = prod;
            state_in = S_P6;
         end
         S_P6: begin
            ma = {{16{reg1[31]}}, reg1[31:16]};
            mb = b6_ff;
            acc_in = ptc_pkg::sdiv_pow2(prod, 5'd13);
            state_in = S_P7;
         end
         S_P7: begin
            ma = {{16{reg3[31]}}, reg3[31:16]};
            mb = sq_ff;
            tmp = acc_ff + ptc_pkg::sdiv_pow2(prod, 5'd16);
            acc_in = ptc_pkg::sdiv_pow2(tmp + 32'd2, 5'd2);
            state_in = S_P8;
         end
         S_P8: begin
            ma = {16'd0, reg1[15:0]};
            mb = acc_ff + 32'd32768;
            acc_in = {15'd0, prod[31:15]};
            state_in = S_P9;
         end
         S_P9: begin
            if (acc_ff == 32'd0) begin
               flt_in = 1'b1;
               done_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               hi_in = b7_ff[31];
               dreq.start = 1'b1;
               dreq.is_signed = 1'b0;
               dreq.dividend = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
               dreq.divisor = acc_ff;
               state_in = S_PDIV;
            end
         end
         S_PDIV: begin
            if (drsp.done) begin
               p_in = hi_ff ? {drsp.quotient[30:0], 1'b0} : drsp.quotient;
               state_in = S_P10;
            end
         end
         S_P10: begin
            tmp = ptc_pkg::sdiv_pow2(p_ff, 5'd8);
            ma = tmp;
            mb = tmp;
            acc_in = prod;
            state_in = S_P11;
         end
         S_P11: begin
            ma = acc_ff;
            mb = 32'd3038;
            acc_in = ptc_pkg::sdiv_pow2(prod, 5'd16);
            state_in = S_P12;
         end
         S_P12: begin
            ma = 32'hFFFF_E343;
            mb = p_ff;
            acc_in = acc_ff + ptc_pkg::sdiv_pow2(prod, 5'd16);
            state_in = S_P13;
         end
         S_P13: begin
            res_in = p_ff + ptc_pkg::sdiv_pow2(acc_ff + 32'd3791, 5'd4);
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         b5_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         b5_ff <= b5_in;
      end
      raw_ff <= raw_in;
      x1_ff <= x1_in;
      b6_ff <= b6_in;
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      b7_ff <= b7_in;
      p_ff <= p_in;
      hi_ff <= hi_in;
      res_ff <= res_in;
      flt_ff <= flt_in;
   end

   assign done = done_ff;
   assign value = res_ff;
   assign fault = flt_ff;

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      done_ff && flt_ff |-> res_ff == 32'd0) else $error("fault with nonzero value");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == S_IDLE) else $error("done while busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> !$past(start) || $past(state_ff) != S_IDLE)
      else $error("start taken while busy");

endmodule

// ----- rtl/core/pressure_temperature_compensation.sv -----
// Top level: APB calibration registers, item handshake and result register.
// Depends on ptc_pkg and ptc_seq.
//
// Usage: write the five calibration words over the APB port (byte address 4*i),
// then send items on req_ (cmd 0 raw temperature, cmd 1 raw pressure).
// A temperature item stores B5 for later pressure items; send one first.
// Each item gives one result on rsp_: kind, value and fault (divisor was zero,
// value 0).
// A temperature item runs one division in the shared divider and then the divide
// by ten by reciprocal multiply; a pressure item runs one division plus the
// multiply steps on the shared multiplier. A zero divisor ends the item early.
// req_stall is high while an item is in work or its result waits; one item is
// in the block at a time. The result is held in a register until rsp_stall is
// low; the next item is taken in the cycle after the result leaves.
// Reset (synchronous) clears the registers, stored B5 and all control state.
module pressure_temperature_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_raw_reading,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic        rsp_fault,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [ptc_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] regs_ff [ptc_pkg::NumRegs];
   logic        busy_ff, busy_in;
   logic        kind_ff, kind_in;
   logic        ovld_ff, ovld_in;
   logic        okind_ff, okind_in;
   logic [31:0] oval_ff, oval_in;
   logic        oflt_ff, oflt_in;
   logic        accept;
   logic        s_done;
   logic [31:0] s_value;
   logic        s_fault;
   logic [2:0]  ridx;

   assign pready = 1'b1;
   assign ridx = paddr[4:2];
   assign req_stall = busy_ff || ovld_ff;
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptc_pkg::NumRegs; i++) regs_ff[i] <= 32'd0;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0 &&
                   ridx <= ptc_pkg::REG_MC_MD) begin
         regs_ff[ridx] <= pwdata;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[1:0] == 2'd0 && ridx <= ptc_pkg::REG_MC_MD) prdata = regs_ff[ridx];
   end

   ptc_seq u_seq (
      .clock(clock), .reset(reset), .start(accept), .cmd(req_cmd),
      .raw_reading(req_raw_reading),
      .reg0(regs_ff[ptc_pkg::REG_AC1_AC2]), .reg1(regs_ff[ptc_pkg::REG_AC3_AC4]),
      .reg2(regs_ff[ptc_pkg::REG_AC5_AC6]), .reg3(regs_ff[ptc_pkg::REG_B1_B2]),
      .reg4(regs_ff[ptc_pkg::REG_MC_MD]),
      .done(s_done), .value(s_value), .fault(s_fault)
   );

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      ovld_in = ovld_ff;
      okind_in = okind_ff;
      oval_in = oval_ff;
      oflt_in = oflt_ff;
      if (ovld_ff && !rsp_stall) ovld_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         kind_in = req_cmd;
      end
      if (s_done) begin
         busy_in = 1'b0;
         ovld_in = 1'b1;
         okind_in = kind_ff;
         oval_in = s_value;
         oflt_in = s_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ovld_ff <= ovld_in;
      end
      kind_ff <= kind_in;
      okind_ff <= okind_in;
      oval_ff <= oval_in;
      oflt_ff <= oflt_in;
   end

   assign rsp_valid = ovld_ff;
   assign rsp_kind = okind_ff;
   assign rsp_value = oval_ff;
   assign rsp_fault = oflt_ff;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      s_done |-> busy_ff && !ovld_ff) else $error("result without item");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && ovld_ff)) else $error("two items in block");
   a_result_fault: assert property (@(posedge clock) disable iff (reset)
      ovld_ff && oflt_ff |-> oval_ff == 32'd0) else $error("fault value nonzero");

endmodule

// ----- dv/tb_pressure_temperature_compensation.sv -----
// Testbench for the pressure/temperature compensation block: random and directed readings.
// Depends on ptc_pkg and the RTL top; predicts each result with an internal integer model.
module tb_pressure_temperature_compensation;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic [15:0] req_raw_reading = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic signed [31:0] rsp_value;
   logic rsp_fault;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ptc_pkg::AddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   pressure_temperature_compensation u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_raw_reading(req_raw_reading),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_value(rsp_value), .rsp_fault(rsp_fault),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      logic        cmd;
      logic [15:0] raw;
   } reading_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        fault;
   } comp_type;

   reading_type pending_q[$];
   comp_type expected_q[$];
   logic [31:0] calib[ptc_pkg::NumRegs];
   logic signed [31:0] b5_saved;
   int mismatches = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   int send_gap = 0, recv_gap = 0;

   function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
      if (a == 32'sh80000000 && b == -1) return a;
      return a / b;
   endfunction

   // compute the compensated result; updates stored B5 on good temperature items
   function automatic comp_type compensate(reading_type it);
      comp_type r;
      logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, raw;
      logic signed [31:0] x1, x2, x3, den, b5, b6, sq, b3, p, q;
      logic [31:0] b4, b7;
      ac1 = $signed(calib[ptc_pkg::REG_AC1_AC2][31:16]);
      ac2 = $signed(calib[ptc_pkg::REG_AC1_AC2][15:0]);
      ac3 = $signed(calib[ptc_pkg::REG_AC3_AC4][31:16]);
      ac4 = {16'd0, calib[ptc_pkg::REG_AC3_AC4][15:0]};
      ac5 = {16'd0, calib[ptc_pkg::REG_AC5_AC6][31:16]};
      ac6 = {16'd0, calib[ptc_pkg::REG_AC5_AC6][15:0]};
      b1 = $signed(calib[ptc_pkg::REG_B1_B2][31:16]);
      b2 = $signed(calib[ptc_pkg::REG_B1_B2][15:0]);
      mc = $signed(calib[ptc_pkg::REG_MC_MD][31:16]);
      md = $signed(calib[ptc_pkg::REG_MC_MD][15:0]);
      raw = {16'd0, it.raw};
      r.kind = it.cmd;
      r.value = '0;
      r.fault = 1'b0;
      if (it.cmd == ptc_pkg::CMD_TEMP) begin
         x1 = tdiv((raw - ac6) * ac5, 32768);
         den = x1 + md;
         if (den == 0) begin
            r.fault = 1'b1;
         end else begin
            x2 = tdiv(2048 * mc, den);
            b5 = x1 + x2;
            b5_saved = b5;
            r.value = tdiv(tdiv(b5 + 8, 16), 10);
         end
      end else begin
         b6 = b5_saved - 4000;
         sq = tdiv(b6 * b6, 4096);
         x1 = tdiv(b2 * sq, 2048);
         x2 = tdiv(ac2 * b6, 2048);
         x3 = x1 + x2;
         b3 = tdiv(ac1 * 4 + x3 + 2, 4);
         x1 = tdiv(ac3 * b6, 8192);
         x2 = tdiv(b1 * sq, 65536);
         x3 = tdiv(x1 + x2 + 2, 4);
         b4 = ($unsigned(ac4) * ($unsigned(x3) + 32'd32768)) / 32'd32768;
         b7 = ($unsigned(raw) - $unsigned(b3)) * 32'd50000;
         if (b4 == 0) begin
            r.fault = 1'b1;
         end else begin
            if (b7 < 32'h80000000) p = (b7 * 2) / b4;
            else p = (b7 / b4) * 2;
            q = tdiv(p, 256);
            x1 = q * q;
            x1 = tdiv(x1 * 3038, 65536);
            x2 = tdiv(-7357 * p, 65536);
            r.value = p + tdiv(x1 + x2 + 3791, 16);
         end
      end
      return r;
   endfunction

   // driver: present the next item, hold it while stalled
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_q.push_back(compensate({req_cmd, req_raw_reading}));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_valid <= 1'b1;
               {req_cmd, req_raw_reading} <= pending_q.pop_front();
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      comp_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result kind=%0d value=%0d fault=%0d",
                  rsp_kind, rsp_value, rsp_fault);
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r != {rsp_kind, rsp_value, rsp_fault}) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: exp kind=%0d value=%0d fault=%0d, got %0d %0d %0d",
                        exp_r.kind, $signed(exp_r.value), exp_r.fault,
                        rsp_kind, rsp_value, rsp_fault);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 2000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      calib[idx] = data;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // realistic calibration word set with random spread (mode 0), all ones (mode 1) or random words (other modes)
   task automatic load_calib(input int mode);
      if (mode == 0) begin
         csr_write(ptc_pkg::REG_AC1_AC2, {16'd408 + 16'($urandom_range(0, 200)), -16'sd72});
         csr_write(ptc_pkg::REG_AC3_AC4,
                   {-16'sd14383, 16'd32741 + 16'($urandom_range(0, 500))});
         csr_write(ptc_pkg::REG_AC5_AC6,
                   {16'd32757 - 16'($urandom_range(0, 9000)), 16'd23153});
         csr_write(ptc_pkg::REG_B1_B2, {16'd6190, 16'd4});
         csr_write(ptc_pkg::REG_MC_MD, {-16'sd8711, 16'd2868 + 16'($urandom_range(0, 300))});
      end else begin
         for (int i = 0; i < ptc_pkg::NumRegs; i++)
            csr_write(3'(i), mode == 1 ? 32'hFFFFFFFF : $urandom());
      end
   endtask

   task automatic add_reading(input logic cmd, input logic [15:0] raw);
      pending_q.push_back({cmd, raw});
   endtask

   initial begin
      for (int i = 0; i < ptc_pkg::NumRegs; i++) calib[i] = '0;
      b5_saved = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // uncalibrated block: temperature divisor is zero
      add_reading(ptc_pkg::CMD_TEMP, 16'd0);
      add_reading(ptc_pkg::CMD_PRES, 16'hFFFF);
      drain();
      load_calib(0);
      add_reading(ptc_pkg::CMD_TEMP, 16'd27898);
      add_reading(ptc_pkg::CMD_PRES, 16'd23843);
      add_reading(ptc_pkg::CMD_TEMP, 16'd0);
      add_reading(ptc_pkg::CMD_TEMP, 16'hFFFF);
      add_reading(ptc_pkg::CMD_PRES, 16'd0);
      add_reading(ptc_pkg::CMD_PRES, 16'hFFFF);
      add_reading(ptc_pkg::CMD_TEMP, 16'h8000);
      add_reading(ptc_pkg::CMD_PRES, 16'h7FFF);
      drain();
      load_calib(1);
      add_reading(ptc_pkg::CMD_TEMP, 16'hFFFF);
      add_reading(ptc_pkg::CMD_PRES, 16'h1234);
      add_reading(ptc_pkg::CMD_TEMP, 16'd0);
      add_reading(ptc_pkg::CMD_PRES, 16'd0);
      drain();
      // zero AC4 forces the pressure divisor to zero
      csr_write(ptc_pkg::REG_AC3_AC4, 32'h00010000);
      add_reading(ptc_pkg::CMD_PRES, 16'd30000);
      drain();
      csr_write(ptc_pkg::REG_MC_MD, 32'h80000000);
      add_reading(ptc_pkg::CMD_TEMP, 16'd100);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         load_calib(ph % 4 == 3 ? 2 : 0);
         if (ph == 7) quiet = 1'b1;
         for (int n = 0; n < 210; n++) begin
            if ($urandom_range(0, 3) == 0) add_reading(ptc_pkg::CMD_TEMP, 16'($urandom()));
            else if ($urandom_range(0, 1)) add_reading(ptc_pkg::CMD_PRES, 16'($urandom()));
            else add_reading(ptc_pkg::CMD_PRES, 16'($urandom_range(20000, 45000)));
         end
         drain();
      end
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
